FILE: src/rsce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsce_pkg
// Shared widths, request and result codes, the result word type and the
// saturating helpers of the route schedule cost evaluator.
// ----------------------------------------------------------------------------
package rsce_pkg;

  localparam int MAX_JOBS_DEF     = 64;
  localparam int MAX_VEHICLES_DEF = 16;
  localparam int OUT_DEPTH        = 16;

  localparam int REQ_W  = 3;
  localparam int NODE_W = 7;
  localparam int JOB_W  = 6;
  localparam int VEH_W  = 4;
  localparam int AMT_W  = 16;
  localparam int TIME_W = 24;
  localparam int WGT_W  = 16;
  localparam int KIND_W = 2;
  localparam int ENT_W  = 6;
  localparam int OBJ_W  = 48;
  localparam int TRV_W  = 32;
  localparam int PROD_W = TIME_W + WGT_W;
  localparam int BASE_W = TRV_W + 1;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 104;

  localparam logic [REQ_W-1:0] REQ_TRAVEL  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_JOB_REC = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PRICE   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_VEHICLE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_JOB     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_END     = 3'd5;

  localparam logic [KIND_W-1:0] KIND_JOB = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VEH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OBJ = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ENT_W-1:0]  entity;
    logic [TIME_W-1:0] time_value;
    logic [TIME_W-1:0] tardiness;
    logic [OBJ_W-1:0]  objective;
    logic              last;
  } result_t;

  // Up to two result words enter the output queue in one cycle.
  typedef struct packed {
    logic [1:0] num;
    result_t    w0;
    result_t    w1;
  } push_t;

  function automatic logic [TIME_W-1:0] sat24(input logic [TIME_W:0] s);
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic logic [TRV_W-1:0] sat32(input logic [TRV_W:0] s);
    return s[TRV_W] ? {TRV_W{1'b1}} : s[TRV_W-1:0];
  endfunction

  function automatic logic [OBJ_W-1:0] sat48(input logic [OBJ_W:0] s);
    return s[OBJ_W] ? {OBJ_W{1'b1}} : s[OBJ_W-1:0];
  endfunction

endpackage

FILE: src/rsce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsce_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rsce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/rsce_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsce_out_fifo
// Result word queue that takes up to two words a cycle and presents one.
// ----------------------------------------------------------------------------
module rsce_out_fifo #(
  parameter int DEPTH = rsce_pkg::OUT_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rsce_pkg::push_t              push,
  output logic                         tvalid,
  input  logic                         tready,
  output rsce_pkg::result_t            word,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rsce_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  wr_ptr;
  logic [CNT_W-1:0]  count;
  logic              pop;

  assign tvalid = (count != '0);
  assign pop    = tvalid && tready;
  assign word   = mem[rd_ptr];
  assign level  = count;

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.w0;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.num);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push.num) - CNT_W'(pop);
    end
  end

endmodule

FILE: src/route_schedule_cost_evaluator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_schedule_cost_evaluator_core
// Scores a production-and-delivery schedule from streamed tables and sequence.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while s_axis_tready is high. Load words
// (travel entries, job records, vehicle prices) write their memory at the
// accept edge; a sequence word reads the travel, job and price memories at the
// accept edge and its result passes through a five-stage pipeline (memory
// read and accumulate, delivery sum, tardiness, weight multiply, penalty sum)
// into the output queue. s_axis_tready drops only when the 16-word result
// queue, counted together with the words still in flight, has no room for
// the two words an end word can produce; with the output taken every cycle the
// rate is one word a cycle. The tables are memories with no reset: the travel
// table holds (MAX_JOBS+1)^2 entries, and a sequence must only touch entries
// already loaded. After an end word the run totals clear and the tables stay.
module route_schedule_cost_evaluator_core #(
  parameter int MAX_JOBS     = rsce_pkg::MAX_JOBS_DEF,
  parameter int MAX_VEHICLES = rsce_pkg::MAX_VEHICLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // node_from, node_to, job_index, vehicle_index, amount, due_time, weight_q8
  input  logic [rsce_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type
  input  logic [rsce_pkg::REQ_W-1:0]          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // entity_index, time_value, tardiness, objective_q8, 2 zero bits
  output logic [rsce_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // result_kind
  output logic [rsce_pkg::KIND_W-1:0]         m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int NODES        = MAX_JOBS + 1;
  localparam int TRAVEL_DEPTH = NODES * NODES;
  localparam int TRAVEL_AW    = (TRAVEL_DEPTH > 1) ? $clog2(TRAVEL_DEPTH) : 1;
  localparam int JOB_AW       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int VEH_AW       = (MAX_VEHICLES > 1) ? $clog2(MAX_VEHICLES) : 1;
  localparam int JOB_RAM_W    = rsce_pkg::AMT_W + rsce_pkg::TIME_W + rsce_pkg::WGT_W;
  localparam int LVL_W        = $clog2(rsce_pkg::OUT_DEPTH + 1);

  typedef enum logic [1:0] {OP_JOB, OP_CLOSE, OP_END} op_t;

  typedef struct packed {
    op_t                              op;
    logic                             close;
    logic                             charge;
    logic [rsce_pkg::ENT_W-1:0]       idx;
    logic [rsce_pkg::TIME_W-1:0]      tval;
    logic [rsce_pkg::TIME_W-1:0]      route;
    logic [rsce_pkg::TIME_W-1:0]      due;
    logic [rsce_pkg::WGT_W-1:0]       wgt;
    logic [rsce_pkg::TIME_W-1:0]      tard;
    logic [rsce_pkg::PROD_W-1:0]      prod;
    logic [rsce_pkg::BASE_W-1:0]      base;
  } pipe_t;

  // Input fields.
  logic [rsce_pkg::REQ_W-1:0]  req_type;
  logic [rsce_pkg::NODE_W-1:0] node_from;
  logic [rsce_pkg::NODE_W-1:0] node_to;
  logic [rsce_pkg::JOB_W-1:0]  job_index;
  logic [rsce_pkg::VEH_W-1:0]  vehicle_index;
  logic [rsce_pkg::AMT_W-1:0]  amount;
  logic [rsce_pkg::TIME_W-1:0] due_time;
  logic [rsce_pkg::WGT_W-1:0]  weight_q8;

  assign req_type      = s_axis_tuser;
  assign node_from     = s_axis_tdata[6:0];
  assign node_to       = s_axis_tdata[13:7];
  assign job_index     = s_axis_tdata[19:14];
  assign vehicle_index = s_axis_tdata[23:20];
  assign amount        = s_axis_tdata[39:24];
  assign due_time      = s_axis_tdata[63:40];
  assign weight_q8     = s_axis_tdata[79:64];

  // Route state, updated at the accept edge.
  logic                        route_open;
  logic                        route_has_jobs;
  logic [rsce_pkg::JOB_W-1:0]  previous_job;
  logic [rsce_pkg::VEH_W-1:0]  current_vehicle;
  logic                        route_open_next;
  logic                        route_has_jobs_next;
  logic [rsce_pkg::JOB_W-1:0]  previous_job_next;
  logic [rsce_pkg::VEH_W-1:0]  current_vehicle_next;

  // Run accumulators, updated in the memory read stage; the penalty total is updated in the penalty sum stage.
  logic [rsce_pkg::TIME_W-1:0] acc_processing;
  logic [rsce_pkg::TIME_W-1:0] route_travel;
  logic [rsce_pkg::TRV_W-1:0]  total_travel;
  logic [rsce_pkg::TIME_W-1:0] total_vehicle_cost;
  logic [rsce_pkg::OBJ_W-1:0]  total_penalty_q8;
  logic [rsce_pkg::TIME_W-1:0] acc_processing_next;
  logic [rsce_pkg::TIME_W-1:0] route_travel_next;
  logic [rsce_pkg::TRV_W-1:0]  total_travel_next;
  logic [rsce_pkg::TIME_W-1:0] total_vehicle_cost_next;
  logic [rsce_pkg::OBJ_W-1:0]  total_penalty_q8_next;

  logic                        in_acc;
  logic                        job_ok;
  logic                        veh_ok;
  logic                        nodes_ok;
  logic                        cur_veh_ok;
  logic                        close_due;
  logic                        enter;
  logic [1:0]                  nres;

  logic                        tr_we;
  logic [TRAVEL_AW-1:0]        tr_waddr;
  logic [TRAVEL_AW-1:0]        tr_raddr;
  logic [rsce_pkg::AMT_W-1:0]  tr_rdata;
  logic                        job_we;
  logic                        job_re;
  logic [JOB_RAM_W-1:0]        job_rdata;
  logic                        pr_we;
  logic                        pr_re;
  logic [rsce_pkg::AMT_W-1:0]  pr_rdata;

  logic [4:0]                  vld;
  pipe_t                       s1, p1, s2, p2, s3, p3, s4, p4, s5, p5;

  logic [rsce_pkg::AMT_W-1:0]  p1_proc;
  logic [rsce_pkg::TIME_W-1:0] p1_due;
  logic [rsce_pkg::WGT_W-1:0]  p1_wgt;
  logic [rsce_pkg::TRV_W-1:0]  travel_closed;

  rsce_pkg::result_t           w_job, w_veh, w_obj, out_word;
  rsce_pkg::push_t             push;
  logic [rsce_pkg::OBJ_W-1:0]  objective;
  logic [LVL_W-1:0]            used;
  logic [LVL_W-1:0]            fifo_level;
  logic                        pop;

  function automatic logic [TRAVEL_AW-1:0] travel_addr(input int from, input int to);
    return TRAVEL_AW'(from * NODES + to);
  endfunction

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (used <= LVL_W'(rsce_pkg::OUT_DEPTH - 2));
  assign job_ok        = int'(job_index) < MAX_JOBS;
  assign veh_ok        = int'(vehicle_index) < MAX_VEHICLES;
  assign nodes_ok      = (int'(node_from) < NODES) && (int'(node_to) < NODES);
  assign cur_veh_ok    = int'(current_vehicle) < MAX_VEHICLES;
  assign close_due     = route_open && route_has_jobs;
  assign tr_waddr      = travel_addr(int'(node_from), int'(node_to));

  // Decode at the accept edge: memory writes, reads and route state.
  always_comb begin
    tr_we                = 1'b0;
    job_we               = 1'b0;
    pr_we                = 1'b0;
    tr_raddr             = travel_addr(int'(previous_job) + 1, 0);
    enter                = 1'b0;
    nres                 = 2'd0;
    s1                   = '0;
    s1.op                = OP_END;
    route_open_next      = route_open;
    route_has_jobs_next  = route_has_jobs;
    previous_job_next    = previous_job;
    current_vehicle_next = current_vehicle;
    case (req_type)
      rsce_pkg::REQ_TRAVEL: begin
        tr_we = in_acc && nodes_ok;
      end
      rsce_pkg::REQ_JOB_REC: begin
        job_we = in_acc && job_ok;
      end
      rsce_pkg::REQ_PRICE: begin
        pr_we = in_acc && veh_ok;
      end
      rsce_pkg::REQ_VEHICLE: begin
        enter                = close_due;
        nres                 = close_due ? 2'd1 : 2'd0;
        s1.op                = OP_CLOSE;
        s1.close             = close_due;
        s1.idx               = rsce_pkg::ENT_W'(current_vehicle);
        current_vehicle_next = vehicle_index;
        route_open_next      = 1'b1;
        route_has_jobs_next  = 1'b0;
      end
      rsce_pkg::REQ_JOB: begin
        if (route_open && job_ok) begin
          enter               = 1'b1;
          nres                = 2'd1;
          s1.op               = OP_JOB;
          s1.idx              = job_index;
          s1.charge           = !route_has_jobs && cur_veh_ok;
          if (route_has_jobs) begin
            tr_raddr = travel_addr(int'(previous_job) + 1, int'(job_index) + 1);
          end else begin
            tr_raddr = travel_addr(0, int'(job_index) + 1);
          end
          route_has_jobs_next = 1'b1;
          previous_job_next   = job_index;
        end
      end
      rsce_pkg::REQ_END: begin
        enter                = 1'b1;
        nres                 = close_due ? 2'd2 : 2'd1;
        s1.op                = OP_END;
        s1.close             = close_due;
        s1.idx               = rsce_pkg::ENT_W'(current_vehicle);
        route_open_next      = 1'b0;
        route_has_jobs_next  = 1'b0;
        previous_job_next    = '0;
        current_vehicle_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign job_re = in_acc && enter && (s1.op == OP_JOB);
  assign pr_re  = job_re && s1.charge;

  rsce_ram #(
    .WIDTH (rsce_pkg::AMT_W),
    .DEPTH (TRAVEL_DEPTH)
  ) u_travel_ram (
    .clk   (clk),
    .we    (tr_we),
    .waddr (tr_waddr),
    .wdata (amount),
    .re    (in_acc && enter),
    .raddr (tr_raddr),
    .rdata (tr_rdata)
  );

  rsce_ram #(
    .WIDTH (JOB_RAM_W),
    .DEPTH (MAX_JOBS)
  ) u_job_ram (
    .clk   (clk),
    .we    (job_we),
    .waddr (JOB_AW'(job_index)),
    .wdata ({weight_q8, due_time, amount}),
    .re    (job_re),
    .raddr (JOB_AW'(job_index)),
    .rdata (job_rdata)
  );

  rsce_ram #(
    .WIDTH (rsce_pkg::AMT_W),
    .DEPTH (MAX_VEHICLES)
  ) u_price_ram (
    .clk   (clk),
    .we    (pr_we),
    .waddr (VEH_AW'(vehicle_index)),
    .wdata (amount),
    .re    (pr_re),
    .raddr (VEH_AW'(current_vehicle)),
    .rdata (pr_rdata)
  );

  assign {p1_wgt, p1_due, p1_proc} = job_rdata;
  assign travel_closed = p1.close
                         ? rsce_pkg::sat32({1'b0, total_travel} + rsce_pkg::BASE_W'(tr_rdata))
                         : total_travel;

  // Memory read stage: run accumulators.
  always_comb begin
    acc_processing_next     = acc_processing;
    route_travel_next       = route_travel;
    total_travel_next       = total_travel;
    total_vehicle_cost_next = total_vehicle_cost;
    s2                      = p1;
    s2.tval                 = acc_processing;
    if (vld[0]) begin
      case (p1.op)
        OP_JOB: begin
          acc_processing_next = rsce_pkg::sat24({1'b0, acc_processing} +
                                                (rsce_pkg::TIME_W + 1)'(p1_proc));
          route_travel_next   = rsce_pkg::sat24({1'b0, route_travel} +
                                                (rsce_pkg::TIME_W + 1)'(tr_rdata));
          total_travel_next   = rsce_pkg::sat32({1'b0, total_travel} +
                                                rsce_pkg::BASE_W'(tr_rdata));
          if (p1.charge) begin
            total_vehicle_cost_next = rsce_pkg::sat24({1'b0, total_vehicle_cost} +
                                                      (rsce_pkg::TIME_W + 1)'(pr_rdata));
          end
          s2.tval  = acc_processing_next;
          s2.route = route_travel_next;
          s2.due   = p1_due;
          s2.wgt   = p1_wgt;
        end
        OP_CLOSE: begin
          total_travel_next = travel_closed;
          route_travel_next = '0;
        end
        OP_END: begin
          s2.base = rsce_pkg::BASE_W'(travel_closed) +
                    rsce_pkg::BASE_W'(total_vehicle_cost);
          acc_processing_next     = '0;
          route_travel_next       = '0;
          total_travel_next       = '0;
          total_vehicle_cost_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Delivery time.
  always_comb begin
    s3 = p2;
    if (p2.op == OP_JOB) begin
      s3.tval = rsce_pkg::sat24({1'b0, p2.tval} + {1'b0, p2.route});
    end
  end

  // Tardiness, clamped at zero.
  always_comb begin
    s4      = p3;
    s4.tard = ((p3.op == OP_JOB) && (p3.tval > p3.due)) ? (p3.tval - p3.due) : '0;
  end

  // Weighted tardiness in 32.8.
  always_comb begin
    s5      = p4;
    s5.prod = rsce_pkg::PROD_W'(p4.tard) * rsce_pkg::PROD_W'(p4.wgt);
  end

  // Penalty sum and result words.
  assign objective = rsce_pkg::sat48((rsce_pkg::OBJ_W + 1)'({p5.base, 8'h00}) +
                                     {1'b0, total_penalty_q8});

  always_comb begin
    w_job            = '0;
    w_job.kind       = rsce_pkg::KIND_JOB;
    w_job.entity     = p5.idx;
    w_job.time_value = p5.tval;
    w_job.tardiness  = p5.tard;
    w_job.last       = 1'b1;
    w_veh            = '0;
    w_veh.kind       = rsce_pkg::KIND_VEH;
    w_veh.entity     = p5.idx;
    w_veh.time_value = p5.tval;
    w_veh.last       = (p5.op == OP_CLOSE);
    w_obj            = '0;
    w_obj.kind       = rsce_pkg::KIND_OBJ;
    w_obj.objective  = objective;
    w_obj.last       = 1'b1;

    push                  = '0;
    push.w1               = w_obj;
    total_penalty_q8_next = total_penalty_q8;
    if (vld[4]) begin
      case (p5.op)
        OP_JOB: begin
          push.num = 2'd1;
          push.w0  = w_job;
          total_penalty_q8_next = rsce_pkg::sat48({1'b0, total_penalty_q8} +
                                                  (rsce_pkg::OBJ_W + 1)'(p5.prod));
        end
        OP_CLOSE: begin
          push.num = 2'd1;
          push.w0  = w_veh;
        end
        OP_END: begin
          push.num              = p5.close ? 2'd2 : 2'd1;
          push.w0               = p5.close ? w_veh : w_obj;
          total_penalty_q8_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p1 <= s1;
    p2 <= s2;
    p3 <= s3;
    p4 <= s4;
    p5 <= s5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld                <= '0;
      route_open         <= 1'b0;
      route_has_jobs     <= 1'b0;
      previous_job       <= '0;
      current_vehicle    <= '0;
      acc_processing     <= '0;
      route_travel       <= '0;
      total_travel       <= '0;
      total_vehicle_cost <= '0;
      total_penalty_q8   <= '0;
      used               <= '0;
    end else begin
      vld <= {vld[3:0], in_acc && enter};
      if (in_acc) begin
        route_open      <= route_open_next;
        route_has_jobs  <= route_has_jobs_next;
        previous_job    <= previous_job_next;
        current_vehicle <= current_vehicle_next;
      end
      acc_processing     <= acc_processing_next;
      route_travel       <= route_travel_next;
      total_travel       <= total_travel_next;
      total_vehicle_cost <= total_vehicle_cost_next;
      total_penalty_q8   <= total_penalty_q8_next;
      // Words reserved at accept, released when the output takes them.
      used <= used + (in_acc ? LVL_W'(nres) : LVL_W'(0)) - LVL_W'(pop);
    end
  end

  rsce_out_fifo #(
    .DEPTH (rsce_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .tvalid (m_axis_tvalid),
    .tready (m_axis_tready),
    .word   (out_word),
    .level  (fifo_level)
  );

  assign pop          = m_axis_tvalid && m_axis_tready;
  assign m_axis_tuser = out_word.kind;
  assign m_axis_tlast = out_word.last;
  assign m_axis_tdata = {2'b00, out_word.objective, out_word.tardiness,
                         out_word.time_value, out_word.entity};

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= LVL_W'(rsce_pkg::OUT_DEPTH))
    else $error("result reservation exceeds queue depth");

  a_level_covered: assert property (@(posedge clk) disable iff (rst)
    fifo_level <= used)
    else $error("queued words not covered by reservation");

  a_end_enters: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (req_type == rsce_pkg::REQ_END)) |=> (vld[0] && (p1.op == OP_END)))
    else $error("end word did not enter the pipeline");

  a_end_clears_route: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (req_type == rsce_pkg::REQ_END)) |=> (!route_open && !route_has_jobs))
    else $error("route state not cleared after end word");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for route_schedule_cost_evaluator_core.
// ----------------------------------------------------------------------------
// Table loads and schedule sequences are streamed into the core. A predictor
// class keeps its own copy of the tables and run totals and queues the result
// words that each accepted word must produce. Output words are compared field
// by field in order. Traffic runs a short directed set, random schedules
// under changing idle patterns, and one long saturating route that begins
// while the output side holds off.
// ----------------------------------------------------------------------------
module tb;
  import rsce_pkg::*;

  localparam int NODES = MAX_JOBS_DEF + 1;
  localparam longint unsigned M24 = 64'hFF_FFFF;
  localparam longint unsigned M32 = 64'hFFFF_FFFF;
  localparam longint unsigned M48 = 64'hFFFF_FFFF_FFFF;
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;
  localparam int SETTLE = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int LONG_ROUTE = 420;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TV_LO = ENT_W;
  localparam int TD_LO = TV_LO + TIME_W;
  localparam int OBJ_LO = TD_LO + TIME_W;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [JOB_W-1:0]  job;
    logic [VEH_W-1:0]  veh;
    logic [AMT_W-1:0]  amount;
    logic [TIME_W-1:0] due;
    logic [WGT_W-1:0]  weight;
  } sched_word_t;

  class schedule_cost_model;
    bit [AMT_W-1:0]  trv_mem [NODES][NODES];
    bit [AMT_W-1:0]  proc_mem [MAX_JOBS_DEF];
    bit [TIME_W-1:0] due_mem [MAX_JOBS_DEF];
    bit [WGT_W-1:0]  wgt_mem [MAX_JOBS_DEF];
    bit [AMT_W-1:0]  price_mem [MAX_VEHICLES_DEF];
    longint unsigned acc_proc, route_trv, tot_trv, tot_veh, tot_pen;
    bit [VEH_W-1:0]  cur_veh;
    bit [JOB_W-1:0]  prev_job;
    bit              route_open, has_jobs;
    result_t         expected_q[$];
    int              errors;
    int              seen [3];
    int              capped;
    longint unsigned top_objective;

    function longint unsigned clamp(longint unsigned s, longint unsigned lim);
      return (s > lim) ? lim : s;
    endfunction

    function void queue_result(logic [KIND_W-1:0] kind, logic [ENT_W-1:0] ent,
                               longint unsigned tv, longint unsigned td,
                               longint unsigned obj, logic last);
      result_t r;
      r.kind = kind;
      r.entity = ent;
      r.time_value = tv[TIME_W-1:0];
      r.tardiness = td[TIME_W-1:0];
      r.objective = obj[OBJ_W-1:0];
      r.last = last;
      expected_q.insert(expected_q.size(), r);
    endfunction

    // Adds the return leg when the route carried jobs; true if a start time is owed.
    function bit close_route();
      bit owed;
      owed = route_open && has_jobs;
      if (owed) tot_trv = clamp(tot_trv + 64'(trv_mem[int'(prev_job) + 1][0]), M32);
      route_open = 1'b0;
      has_jobs = 1'b0;
      route_trv = 0;
      return owed;
    endfunction

    function void note_word(sched_word_t w);
      bit [VEH_W-1:0] closed_veh;
      longint unsigned leg, deliv, tard, obj;
      int jn;
      closed_veh = cur_veh;
      jn = int'(w.job) + 1;
      case (w.req)
        REQ_TRAVEL: begin
          if (w.from_node < NODES && w.to_node < NODES)
            trv_mem[w.from_node][w.to_node] = w.amount;
        end
        REQ_JOB_REC: begin
          proc_mem[w.job] = w.amount;
          due_mem[w.job] = w.due;
          wgt_mem[w.job] = w.weight;
        end
        REQ_PRICE: price_mem[w.veh] = w.amount;
        REQ_VEHICLE: begin
          if (close_route()) queue_result(KIND_VEH, ENT_W'(closed_veh), acc_proc, 0, 0, 1'b1);
          cur_veh = w.veh;
          route_open = 1'b1;
        end
        REQ_JOB: begin
          if (route_open) begin
            if (!has_jobs) begin
              leg = 64'(trv_mem[0][jn]);
              tot_veh = clamp(tot_veh + 64'(price_mem[cur_veh]), M24);
              has_jobs = 1'b1;
            end else begin
              leg = 64'(trv_mem[int'(prev_job) + 1][jn]);
            end
            route_trv = clamp(route_trv + leg, M24);
            tot_trv = clamp(tot_trv + leg, M32);
            acc_proc = clamp(acc_proc + 64'(proc_mem[w.job]), M24);
            deliv = clamp(acc_proc + route_trv, M24);
            tard = (deliv > 64'(due_mem[w.job])) ? deliv - 64'(due_mem[w.job]) : 0;
            tot_pen = clamp(tot_pen + tard * 64'(wgt_mem[w.job]), M48);
            prev_job = w.job;
            if (deliv == M24) capped++;
            queue_result(KIND_JOB, w.job, deliv, tard, 0, 1'b1);
          end
        end
        REQ_END: begin
          if (close_route()) queue_result(KIND_VEH, ENT_W'(closed_veh), acc_proc, 0, 0, 1'b0);
          obj = clamp(((tot_trv + tot_veh) << 8) + tot_pen, M48);
          if (obj > top_objective) top_objective = obj;
          queue_result(KIND_OBJ, '0, 0, 0, obj, 1'b1);
          // The tables survive; only the run state starts over.
          acc_proc = 0;
          tot_trv = 0;
          tot_veh = 0;
          tot_pen = 0;
          cur_veh = '0;
          prev_job = '0;
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, longint unsigned exp_v, longint unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        $error("result word of kind %0d arrived with nothing expected", got.kind);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      compare_field("result_kind", 64'(exp.kind), 64'(got.kind));
      compare_field("entity_index", 64'(exp.entity), 64'(got.entity));
      compare_field("time_value", 64'(exp.time_value), 64'(got.time_value));
      compare_field("tardiness", 64'(exp.tardiness), 64'(got.tardiness));
      compare_field("objective_q8", 64'(exp.objective), 64'(got.objective));
      compare_field("last", 64'(exp.last), 64'(got.last));
      if (got.kind <= KIND_OBJ) seen[got.kind]++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [REQ_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]     m_axis_tuser;
  logic                  m_axis_tlast;

  schedule_cost_model sb;
  bit   trv_ok [NODES][NODES];
  bit   job_ok [MAX_JOBS_DEF];
  bit   price_ok [MAX_VEHICLES_DEF];
  int   n_sent = 0;
  int   tx_idle = 36;
  int   rx_idle = 87;
  logic [7:0] hold_seq = '0;
  logic [7:0] hold_seen = '0;
  int   hold_left = 0;
  int   cycle_cnt = 0;
  result_t out_word;

  route_schedule_cost_evaluator_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Output side: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      out_word.kind = m_axis_tuser;
      out_word.entity = m_axis_tdata[ENT_W-1:0];
      out_word.time_value = m_axis_tdata[TV_LO +: TIME_W];
      out_word.tardiness = m_axis_tdata[TD_LO +: TIME_W];
      out_word.objective = m_axis_tdata[OBJ_LO +: OBJ_W];
      out_word.last = m_axis_tlast;
      sb.check_result(out_word);
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic sched_word_t fresh(logic [REQ_W-1:0] req);
    sched_word_t w;
    w.req = req;
    w.from_node = NODE_W'($urandom);
    w.to_node = NODE_W'($urandom);
    w.job = JOB_W'($urandom);
    w.veh = VEH_W'($urandom);
    w.amount = AMT_W'($urandom);
    w.due = TIME_W'($urandom);
    w.weight = WGT_W'($urandom);
    return w;
  endfunction

  function automatic logic [AMT_W-1:0] pick_amount();
    return ($urandom_range(9) == 0) ? AMT_W'($urandom) : AMT_W'($urandom_range(400));
  endfunction

  function automatic logic [TIME_W-1:0] pick_due();
    return ($urandom_range(3) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(4000));
  endfunction

  task automatic send_word(sched_word_t w);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {w.weight, w.due, w.amount, w.veh, w.job, w.to_node, w.from_node};
    s_axis_tuser <= w.req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_word(w);
    case (w.req)
      REQ_TRAVEL: begin
        if (w.from_node < NODES && w.to_node < NODES) trv_ok[w.from_node][w.to_node] = 1'b1;
      end
      REQ_JOB_REC: job_ok[w.job] = 1'b1;
      REQ_PRICE: price_ok[w.veh] = 1'b1;
      default: ;
    endcase
    if (w.req <= REQ_END) n_sent++;
  endtask

  task automatic load_travel(logic [NODE_W-1:0] f, logic [NODE_W-1:0] t,
                             logic [AMT_W-1:0] a);
    sched_word_t w;
    w = fresh(REQ_TRAVEL);
    w.from_node = f;
    w.to_node = t;
    w.amount = a;
    send_word(w);
  endtask

  task automatic load_job(logic [JOB_W-1:0] j, logic [AMT_W-1:0] p,
                          logic [TIME_W-1:0] d, logic [WGT_W-1:0] wt);
    sched_word_t w;
    w = fresh(REQ_JOB_REC);
    w.job = j;
    w.amount = p;
    w.due = d;
    w.weight = wt;
    send_word(w);
  endtask

  task automatic load_price(logic [VEH_W-1:0] v, logic [AMT_W-1:0] a);
    sched_word_t w;
    w = fresh(REQ_PRICE);
    w.veh = v;
    w.amount = a;
    send_word(w);
  endtask

  task automatic mark_vehicle(logic [VEH_W-1:0] v);
    sched_word_t w;
    w = fresh(REQ_VEHICLE);
    w.veh = v;
    send_word(w);
  endtask

  task automatic run_job(logic [JOB_W-1:0] j);
    sched_word_t w;
    w = fresh(REQ_JOB);
    w.job = j;
    send_word(w);
  endtask

  task automatic finish_run();
    send_word(fresh(REQ_END));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic ensure_leg(int f, int t);
    if (!trv_ok[f][t]) load_travel(NODE_W'(f), NODE_W'(t), pick_amount());
  endtask

  // A route that carried jobs reads its return leg when it closes.
  task automatic ensure_return();
    if (sb.route_open && sb.has_jobs) ensure_leg(int'(sb.prev_job) + 1, 0);
  endtask

  task automatic pick_job(output logic [JOB_W-1:0] j);
    j = ($urandom_range(3) == 0) ? JOB_W'($urandom) : JOB_W'($urandom_range(7));
    if (!job_ok[j]) load_job(j, pick_amount(), pick_due(), WGT_W'($urandom));
  endtask

  task automatic random_load();
    int f, t;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        f = $urandom_range(64);
        t = $urandom_range(64);
        if ($urandom_range(7) == 0) f = $urandom_range(127, 65);
        else if ($urandom_range(7) == 0) t = $urandom_range(127, 65);
        load_travel(NODE_W'(f), NODE_W'(t), pick_amount());
      end
      5, 6: load_job(JOB_W'($urandom), pick_amount(), pick_due(), WGT_W'($urandom));
      7: load_price(VEH_W'($urandom), pick_amount());
      default: send_word(fresh($urandom_range(1) ? REQ_SPARE_A : REQ_SPARE_B));
    endcase
  endtask

  task automatic random_schedule();
    logic [JOB_W-1:0] j;
    logic [VEH_W-1:0] v;
    int n_jobs;
    repeat ($urandom_range(4)) random_load();
    if ($urandom_range(9) == 0) begin
      // No route is open yet, so this job is dropped.
      pick_job(j);
      run_job(j);
    end
    repeat ($urandom_range(4, 1)) begin
      v = VEH_W'($urandom);
      if (!price_ok[v]) load_price(v, pick_amount());
      ensure_return();
      mark_vehicle(v);
      n_jobs = $urandom_range(5);
      repeat (n_jobs) begin
        if ($urandom_range(7) == 0) random_load();
        pick_job(j);
        ensure_leg(sb.has_jobs ? int'(sb.prev_job) + 1 : 0, int'(j) + 1);
        run_job(j);
      end
    end
    ensure_return();
    finish_run();
    if ($urandom_range(7) == 0) drain();
  endtask

  // One job repeated on a single route until delivery, penalty and objective
  // all hit their ceilings; the output side holds off as the route begins.
  task automatic saturating_run();
    logic [JOB_W-1:0] j;
    logic [VEH_W-1:0] v;
    logic [NODE_W-1:0] jn;
    j = JOB_W'($urandom);
    v = VEH_W'($urandom);
    jn = NODE_W'(j) + 7'd1;
    load_job(j, 16'hFFFF, TIME_W'($urandom_range(5000)), 16'hFFFF);
    load_travel(7'd0, jn, 16'hFFFF);
    load_travel(jn, jn, 16'hFFFF);
    load_travel(jn, 7'd0, pick_amount());
    load_price(v, 16'hFFFF);
    hold_seq <= hold_seq + 8'd1;
    mark_vehicle(v);
    repeat (LONG_ROUTE) run_job(j);
    finish_run();
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: ignored codes, an empty schedule, table extremes, a job with
    // no open route, an empty vehicle, and both ways a route can close.
    send_word(fresh(REQ_SPARE_A));
    send_word(fresh(REQ_SPARE_B));
    finish_run();
    load_price(4'd15, 16'hFFFF);
    load_price(4'd0, 16'h0000);
    load_job(6'd63, 16'hFFFF, 24'h000000, 16'hFFFF);
    load_job(6'd0, 16'h0000, 24'hFFFFFF, 16'h0000);
    load_travel(7'd0, 7'd64, 16'hFFFF);
    load_travel(7'd64, 7'd1, 16'h0000);
    load_travel(7'd1, 7'd0, 16'h8001);
    load_travel(7'd0, 7'd1, 16'h0001);
    load_travel(7'd65, 7'd0, AMT_W'($urandom));
    load_travel(7'd127, 7'd127, 16'hFFFF);
    run_job(6'd0);
    mark_vehicle(4'd0);
    mark_vehicle(4'd15);
    run_job(6'd63);
    run_job(6'd0);
    mark_vehicle(4'd0);
    run_job(6'd0);
    finish_run();

    while (n_sent < 320) random_schedule();
    tx_idle = 87;
    rx_idle <= 36;
    while (n_sent < 580) random_schedule();
    drain();
    tx_idle = 0;
    rx_idle <= 0;
    saturating_run();
    while (n_sent < 1080) random_schedule();
    drain();

    if (sb.expected_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_q.size());
      sb.errors++;
    end
    $display("tb: %0d words driven; %0d job, %0d vehicle and %0d objective results checked",
             n_sent, sb.seen[0], sb.seen[1], sb.seen[2]);
    $display("tb: %0d delivery times at the ceiling, largest objective 0x%0h",
             sb.capped, sb.top_objective);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
